// ===== hdl/smps_pkg.sv =====
// ----------------------------------------------------------------------------
// smps_pkg: servo motion profile sequencer package
// Shared types, codes, fixed-point constants and the sine lookup table.
// ----------------------------------------------------------------------------
package smps_pkg;

    localparam int SINE_ENTRIES      = 256;
    localparam int SINE_BITS         = $clog2(SINE_ENTRIES);
    localparam int DIV_W             = 32 + SINE_BITS;
    localparam int WRITE_INTERVAL_MS = 20;
    localparam int EASE_IN_MS        = 1000;
    localparam int CENTRE            = 90;
    localparam int ANGLE_MAX         = 180;
    localparam int HOLD_JOG_MS       = 250;
    localparam int WAGGLE_MIN_MS     = 50;
    localparam int DIV10_RECIP       = 52429;
    localparam int DIV10_SHIFT       = 19;

    typedef enum logic [2:0] {
        ACT_TICK      = 3'd0,
        ACT_JOG       = 3'd1,
        ACT_HOLD      = 3'd2,
        ACT_WAGGLE    = 3'd3,
        ACT_THINK_ON  = 3'd4,
        ACT_THINK_OFF = 3'd5,
        ACT_CANCEL    = 3'd6,
        ACT_CONSUME   = 3'd7
    } t_action;

    typedef enum logic [1:0] {
        CFG_SAFE_MIN  = 2'd0,
        CFG_SAFE_MAX  = 2'd1,
        CFG_SERVO_EN  = 2'd2
    } t_cfg_index;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_WAG,
        S_JOG,
        S_JOG_DIV,
        S_SM1,
        S_SM2,
        S_SM3,
        S_JOG_MUL,
        S_JOG_WR,
        S_THINK,
        S_TH_DIV,
        S_TH_BASE,
        S_TH_AMP,
        S_TH_AE,
        S_TH_IDX,
        S_TH_DMUL,
        S_TH_SUM,
        S_TH_WR,
        S_DONE
    } t_state;

    typedef struct packed {
        t_action             action;
        logic signed [7:0]   offset_deg;
        logic [7:0]          amplitude;
        logic [15:0]         period_ms;
        logic [23:0]         duration_ms;
    } t_in;

    typedef struct packed {
        logic [7:0] angle;
        logic       angle_valid;
        logic       hold_expired;
        logic       busy_res;
    } t_out;

    typedef logic signed [15:0] t_sine_tab [SINE_ENTRIES];

    function automatic t_sine_tab f_sine_tab();
        t_sine_tab  tab;
        logic [63:0] u;
        logic [63:0] r;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] s;
        logic [63:0] v;
        logic [1:0]  quad;
        for (int i = 0; i < SINE_ENTRIES; i++) begin
            u    = (64'(i) * 64'd65536) / SINE_ENTRIES;
            quad = u[15:14];
            r    = u & 64'h3FFF;
            if (quad[0]) begin
                r = 64'd16384 - r;
            end
            x  = r << 2;
            x2 = (x * x) >> 16;
            s  = 64'd307;
            s  = 64'd5223 - ((s * x2) >> 16);
            s  = 64'd42334 - ((s * x2) >> 16);
            s  = 64'd102944 - ((s * x2) >> 16);
            v  = (((s * x) >> 16) + 64'd1) >> 1;
            if (v > 64'd32767) begin
                v = 64'd32767;
            end
            tab[i] = quad[1] ? -$signed(16'(v)) : $signed(16'(v));
        end
        return tab;
    endfunction

    localparam t_sine_tab SINE_TAB = f_sine_tab();

endpackage

// ===== hdl/smps_div.sv =====
// ----------------------------------------------------------------------------
// smps_div: iterative restoring divider
// One quotient bit per cycle; dividend DIV_W bits, divisor 16 bits.
// ----------------------------------------------------------------------------
module smps_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [smps_pkg::DIV_W-1:0] i_dividend,
    input  logic [15:0]                i_divisor,
    output logic                       o_busy,
    output logic [smps_pkg::DIV_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(smps_pkg::DIV_W + 1);

    logic [CNT_W-1:0]          r_cnt;
    logic [smps_pkg::DIV_W-1:0] r_quo;
    logic [15:0]               r_rem;
    logic [15:0]               r_div;
    logic [16:0]               trial;
    logic                      ge;

    assign trial = {r_rem, r_quo[smps_pkg::DIV_W-1]};
    assign ge    = trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(smps_pkg::DIV_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_cnt != '0) begin
            r_rem <= ge ? 16'(trial - {1'b0, r_div}) : trial[15:0];
            r_quo <= {r_quo[smps_pkg::DIV_W-2:0], ge};
        end
    end

    assign o_busy = r_cnt != '0;
    assign o_quot = r_quo;

endmodule

// ===== hdl/servo_motion_profile_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// servo_motion_profile_sequencer_unit: servo jog/hold/waggle/think sequencer
// Jog writes use one pass of the shared divider; think writes use two during
// ease-in (time fraction, then sine index) and one after it.
// Throughput: one item at a time; the next item is taken once the result is
// in the output register. Reset is synchronous: all motion state returns to
// its defaults; the waggle keyframe store is not cleared.
// ----------------------------------------------------------------------------
module servo_motion_profile_sequencer_unit (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  smps_pkg::t_in  i_in_data,
    output logic           o_in_stall,
    output logic           o_out_valid,
    output smps_pkg::t_out o_out_data,
    input  logic           i_out_stall,
    input  logic           i_cfg_we,
    input  logic [1:0]     i_cfg_index,
    input  logic [7:0]     i_cfg_data
);

    smps_pkg::t_state r_state, n_state;
    smps_pkg::t_in    r_in;
    smps_pkg::t_out   r_out_data;
    logic             r_out_valid;

    logic signed [7:0] r_safe_min, r_safe_max;
    logic              r_servo_en;

    logic [31:0] r_now;
    logic [7:0]  r_cmd_angle;
    logic        r_jog_act;
    logic [7:0]  r_jog_from, r_jog_to;
    logic [31:0] r_jog_begin, r_jog_last;
    logic [15:0] r_jog_len;
    logic        r_pat_act;
    logic [2:0]  r_frame;
    logic [31:0] r_frame_begin;
    logic [7:0]  r_wag [3];
    logic [15:0] r_wag_dwell;
    logic        r_think_act;
    logic [31:0] r_think_begin, r_think_last;
    logic [7:0]  r_think_from;
    logic signed [7:0] r_think_centre;
    logic [7:0]  r_think_amp;
    logic [15:0] r_think_period;
    logic        r_hold_act;
    logic [31:0] r_hold_end;
    logic        r_hold_flag;
    logic        r_wrote, r_expired;
    logic        r_is_think;

    logic [15:0]        r_t;
    logic [16:0]        r_s;
    logic [23:0]        r_base;
    logic [24:0]        r_ae;
    logic signed [15:0] r_sin;
    logic signed [26:0] r_sum;
    logic signed [44:0] r_p;

    logic signed [25:0] mul_a;
    logic signed [18:0] mul_b;
    logic                       div_start, div_busy;
    logic [smps_pkg::DIV_W-1:0] div_dividend, div_quot;
    logic [15:0]                div_divisor;

    logic        in_xfer, out_load;
    logic [31:0] hold_diff, jog_elapsed, jog_since_wr, think_since, think_since_wr;
    logic [31:0] frame_dt;
    logic        hold_exp, hold_blocks;
    logic [15:0] wag_per;
    logic [15:0] jog_len_cmd;
    logic [23:0] hold_dur;
    logic signed [8:0]  jog_d, think_d;
    logic [7:0]  think_target;
    logic signed [44:0] jog_adj, jog_q, dm_adj, dm_q;
    logic signed [26:0] sum_adj, sum_q;
    logic [8:0]  jog_angle;
    logic [2:0]  frame_nx;

    function automatic logic [7:0] f_angle(logic signed [11:0] off,
                                           logic signed [7:0] smin,
                                           logic signed [7:0] smax);
        logic signed [11:0] o;
        logic signed [11:0] a;
        o = off;
        if (o < 12'(smin)) begin
            o = 12'(smin);
        end
        if (o > 12'(smax)) begin
            o = 12'(smax);
        end
        a = o + 12'sd90;
        if (a < 12'sd0) begin
            a = 12'sd0;
        end
        if (a > 12'(smps_pkg::ANGLE_MAX)) begin
            a = 12'(smps_pkg::ANGLE_MAX);
        end
        return a[7:0];
    endfunction

    function automatic logic [1:0] f_slot(logic [2:0] frame);
        logic [1:0] s;
        case (frame)
            3'd1, 3'd3: s = 2'd1;
            3'd2:       s = 2'd2;
            default:    s = 2'd0;
        endcase
        return s;
    endfunction

    smps_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_busy     (div_busy),
        .o_quot     (div_quot)
    );

    assign o_in_stall  = r_state != smps_pkg::S_IDLE;
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign out_load    = (r_state == smps_pkg::S_DONE) && (!r_out_valid || !i_out_stall);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign hold_diff      = r_now - r_hold_end;
    assign hold_exp       = !hold_diff[31];
    assign hold_blocks    = r_hold_act && !hold_exp;
    assign jog_elapsed    = r_now - r_jog_begin;
    assign jog_since_wr   = r_now - r_jog_last;
    assign think_since    = r_now - r_think_begin;
    assign think_since_wr = r_now - r_think_last;
    assign frame_dt       = r_now - r_frame_begin;
    assign frame_nx       = r_frame + 3'd1;

    assign wag_per      = (r_in.period_ms < 16'(smps_pkg::WAGGLE_MIN_MS)) ?
                          16'(smps_pkg::WAGGLE_MIN_MS) : r_in.period_ms;
    assign jog_len_cmd  = (r_in.duration_ms > 24'hFFFF) ? 16'hFFFF :
                          (r_in.duration_ms == '0) ? 16'd1 : r_in.duration_ms[15:0];
    assign hold_dur     = (r_in.duration_ms == '0) ? 24'd1 : r_in.duration_ms;

    assign jog_d        = $signed({1'b0, r_jog_to}) - $signed({1'b0, r_jog_from});
    assign think_target = f_angle(12'(r_think_centre), r_safe_min, r_safe_max);
    assign think_d      = $signed({1'b0, think_target}) - $signed({1'b0, r_think_from});

    assign jog_adj   = r_p + (r_p[44] ? 45'sd65535 : 45'sd0);
    assign jog_q     = jog_adj >>> 16;
    assign jog_angle = {1'b0, r_jog_from} + jog_q[8:0];
    assign dm_adj    = r_p + (r_p[44] ? 45'sd32767 : 45'sd0);
    assign dm_q      = dm_adj >>> 15;
    assign sum_adj   = r_sum + (r_sum[26] ? 27'sd65535 : 27'sd0);
    assign sum_q     = sum_adj >>> 16;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= smps_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        mul_a        = '0;
        mul_b        = '0;
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = 16'd1;
        unique case (r_state)
            smps_pkg::S_IDLE: begin
                if (in_xfer) begin
                    n_state = smps_pkg::S_DISPATCH;
                end
            end
            smps_pkg::S_DISPATCH: begin
                n_state = smps_pkg::S_DONE;
                if (r_servo_en) begin
                    if (r_in.action == smps_pkg::ACT_TICK) begin
                        if (hold_blocks || r_jog_act) begin
                            n_state = r_jog_act ? smps_pkg::S_JOG : smps_pkg::S_DONE;
                        end else if (!r_pat_act && r_think_act) begin
                            n_state = smps_pkg::S_THINK;
                        end
                    end else if (r_in.action == smps_pkg::ACT_WAGGLE &&
                                 !r_pat_act && !r_jog_act) begin
                        mul_a   = 26'(wag_per);
                        mul_b   = 19'(smps_pkg::DIV10_RECIP);
                        n_state = smps_pkg::S_WAG;
                    end
                end
            end
            smps_pkg::S_WAG: n_state = smps_pkg::S_DONE;
            smps_pkg::S_JOG: begin
                n_state = smps_pkg::S_DONE;
                if (jog_elapsed < {16'd0, r_jog_len} &&
                    jog_since_wr >= 32'(smps_pkg::WRITE_INTERVAL_MS)) begin
                    div_start    = 1'b1;
                    div_dividend = smps_pkg::DIV_W'({jog_elapsed[15:0], 16'd0});
                    div_divisor  = r_jog_len;
                    n_state      = smps_pkg::S_JOG_DIV;
                end
            end
            smps_pkg::S_JOG_DIV: begin
                if (!div_busy) begin
                    n_state = smps_pkg::S_SM1;
                end
            end
            smps_pkg::S_SM1: begin
                mul_a   = 26'(r_t);
                mul_b   = 19'(r_t);
                n_state = smps_pkg::S_SM2;
            end
            smps_pkg::S_SM2: begin
                mul_a   = 26'(r_p[31:16]);
                mul_b   = 19'(18'd196608 - {1'b0, r_t, 1'b0});
                n_state = smps_pkg::S_SM3;
            end
            smps_pkg::S_SM3: begin
                n_state = r_is_think ? smps_pkg::S_TH_BASE : smps_pkg::S_JOG_MUL;
            end
            smps_pkg::S_JOG_MUL: begin
                mul_a   = 26'(jog_d);
                mul_b   = 19'(r_s);
                n_state = smps_pkg::S_JOG_WR;
            end
            smps_pkg::S_JOG_WR: n_state = smps_pkg::S_DONE;
            smps_pkg::S_THINK: begin
                if (think_since_wr < 32'(smps_pkg::WRITE_INTERVAL_MS)) begin
                    n_state = smps_pkg::S_DONE;
                end else if (think_since < 32'(smps_pkg::EASE_IN_MS)) begin
                    div_start    = 1'b1;
                    div_dividend = smps_pkg::DIV_W'({think_since[15:0], 16'd0});
                    div_divisor  = 16'(smps_pkg::EASE_IN_MS);
                    n_state      = smps_pkg::S_TH_DIV;
                end else begin
                    n_state = smps_pkg::S_TH_BASE;
                end
            end
            smps_pkg::S_TH_DIV: begin
                if (!div_busy) begin
                    n_state = smps_pkg::S_SM1;
                end
            end
            smps_pkg::S_TH_BASE: begin
                mul_a        = 26'(think_d);
                mul_b        = 19'(r_s);
                div_start    = 1'b1;
                div_dividend = {r_now, smps_pkg::SINE_BITS'(0)};
                div_divisor  = r_think_period;
                n_state      = smps_pkg::S_TH_AMP;
            end
            smps_pkg::S_TH_AMP: begin
                mul_a   = 26'(r_think_amp);
                mul_b   = 19'(r_s);
                n_state = smps_pkg::S_TH_AE;
            end
            smps_pkg::S_TH_AE: n_state = smps_pkg::S_TH_IDX;
            smps_pkg::S_TH_IDX: begin
                if (!div_busy) begin
                    n_state = smps_pkg::S_TH_DMUL;
                end
            end
            smps_pkg::S_TH_DMUL: begin
                mul_a   = 26'(r_ae);
                mul_b   = 19'(r_sin);
                n_state = smps_pkg::S_TH_SUM;
            end
            smps_pkg::S_TH_SUM: n_state = smps_pkg::S_TH_WR;
            smps_pkg::S_TH_WR:  n_state = smps_pkg::S_DONE;
            smps_pkg::S_DONE: begin
                if (out_load) begin
                    n_state = smps_pkg::S_IDLE;
                end
            end
            default: n_state = smps_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_p <= mul_a * mul_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_safe_min <= -8'sd90;
            r_safe_max <= 8'sd90;
            r_servo_en <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                smps_pkg::CFG_SAFE_MIN: r_safe_min <= $signed(i_cfg_data);
                smps_pkg::CFG_SAFE_MAX: r_safe_max <= $signed(i_cfg_data);
                smps_pkg::CFG_SERVO_EN: r_servo_en <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data.angle        <= r_cmd_angle;
            r_out_data.angle_valid  <= r_wrote;
            r_out_data.hold_expired <= r_expired;
            r_out_data.busy_res     <= r_pat_act | r_jog_act | r_hold_act;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            smps_pkg::S_WAG: begin
                r_wag_dwell <= r_p[smps_pkg::DIV10_SHIFT+15:smps_pkg::DIV10_SHIFT];
                r_wag[0] <= f_angle(12'(r_in.offset_deg), r_safe_min, r_safe_max);
                r_wag[1] <= f_angle(12'(r_in.offset_deg) + $signed({4'd0, r_in.amplitude}),
                                    r_safe_min, r_safe_max);
                r_wag[2] <= f_angle(12'(r_in.offset_deg) - $signed({4'd0, r_in.amplitude}),
                                    r_safe_min, r_safe_max);
            end
            smps_pkg::S_JOG_DIV, smps_pkg::S_TH_DIV: r_t <= div_quot[15:0];
            smps_pkg::S_TH_AMP: r_base <= 24'({r_think_from, 16'd0} + r_p[23:0]);
            smps_pkg::S_TH_AE:  r_ae <= r_p[24:0];
            smps_pkg::S_TH_IDX: r_sin <= smps_pkg::SINE_TAB[div_quot[smps_pkg::SINE_BITS-1:0]];
            smps_pkg::S_TH_SUM: begin
                r_sum <= $signed({3'd0, r_base}) + dm_q[26:0]
                         - 27'(smps_pkg::CENTRE * 65536);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now          <= '0;
            r_cmd_angle    <= 8'(smps_pkg::CENTRE);
            r_jog_act      <= 1'b0;
            r_jog_from     <= 8'(smps_pkg::CENTRE);
            r_jog_to       <= 8'(smps_pkg::CENTRE);
            r_jog_begin    <= '0;
            r_jog_last     <= '0;
            r_jog_len      <= 16'(smps_pkg::HOLD_JOG_MS);
            r_pat_act      <= 1'b0;
            r_frame        <= '0;
            r_frame_begin  <= '0;
            r_think_act    <= 1'b0;
            r_think_begin  <= '0;
            r_think_last   <= '0;
            r_think_from   <= 8'(smps_pkg::CENTRE);
            r_think_centre <= '0;
            r_think_amp    <= 8'd5;
            r_think_period <= 16'd2000;
            r_hold_act     <= 1'b0;
            r_hold_end     <= '0;
            r_hold_flag    <= 1'b0;
            r_wrote        <= 1'b0;
            r_expired      <= 1'b0;
            r_is_think     <= 1'b0;
            r_s            <= '0;
        end else begin
            case (r_state)
                smps_pkg::S_IDLE: begin
                    if (in_xfer) begin
                        r_in      <= i_in_data;
                        r_wrote   <= 1'b0;
                        r_expired <= 1'b0;
                        if (i_in_data.action == smps_pkg::ACT_TICK) begin
                            r_now <= r_now + 32'd1;
                        end
                    end
                end
                smps_pkg::S_DISPATCH: begin
                    if (r_servo_en) begin
                        unique case (r_in.action)
                            smps_pkg::ACT_TICK: begin
                                if (r_hold_act && hold_exp) begin
                                    r_hold_act  <= 1'b0;
                                    r_hold_flag <= 1'b1;
                                end
                                if (!hold_blocks && !r_jog_act && r_pat_act &&
                                    frame_dt >= {16'd0, r_wag_dwell}) begin
                                    if (frame_nx >= 3'd5) begin
                                        r_frame   <= 3'd5;
                                        r_pat_act <= 1'b0;
                                    end else begin
                                        r_frame       <= frame_nx;
                                        r_frame_begin <= r_now;
                                        r_cmd_angle   <= r_wag[f_slot(frame_nx)];
                                        r_wrote       <= 1'b1;
                                    end
                                end
                            end
                            smps_pkg::ACT_JOG, smps_pkg::ACT_HOLD: begin
                                r_jog_from  <= r_cmd_angle;
                                r_jog_to    <= f_angle(12'(r_in.offset_deg),
                                                       r_safe_min, r_safe_max);
                                r_jog_begin <= r_now;
                                r_jog_last  <= '0;
                                r_jog_act   <= 1'b1;
                                r_pat_act   <= 1'b0;
                                if (r_in.action == smps_pkg::ACT_HOLD) begin
                                    r_jog_len   <= 16'(smps_pkg::HOLD_JOG_MS);
                                    r_hold_act  <= 1'b1;
                                    r_hold_end  <= r_now + 32'(hold_dur);
                                    r_hold_flag <= 1'b0;
                                end else begin
                                    r_jog_len <= jog_len_cmd;
                                end
                            end
                            smps_pkg::ACT_WAGGLE: begin
                                if (!r_pat_act && !r_jog_act) begin
                                    r_pat_act     <= 1'b1;
                                    r_frame       <= '0;
                                    r_frame_begin <= r_now;
                                    r_cmd_angle   <= f_angle(12'(r_in.offset_deg),
                                                             r_safe_min, r_safe_max);
                                    r_wrote       <= 1'b1;
                                end
                            end
                            smps_pkg::ACT_THINK_ON: begin
                                r_think_act    <= 1'b1;
                                r_think_begin  <= r_now;
                                r_think_from   <= r_cmd_angle;
                                r_think_last   <= '0;
                                r_think_centre <= r_in.offset_deg;
                                r_think_amp    <= r_in.amplitude;
                                r_think_period <= (r_in.period_ms == '0) ? 16'd1 :
                                                  r_in.period_ms;
                            end
                            smps_pkg::ACT_THINK_OFF: r_think_act <= 1'b0;
                            smps_pkg::ACT_CANCEL: begin
                                r_pat_act   <= 1'b0;
                                r_jog_act   <= 1'b0;
                                r_think_act <= 1'b0;
                            end
                            smps_pkg::ACT_CONSUME: begin
                                r_expired   <= r_hold_flag;
                                r_hold_flag <= 1'b0;
                            end
                            default: ;
                        endcase
                    end
                end
                smps_pkg::S_JOG: begin
                    r_is_think <= 1'b0;
                    if (jog_elapsed >= {16'd0, r_jog_len}) begin
                        r_cmd_angle <= r_jog_to;
                        r_wrote     <= 1'b1;
                        r_jog_act   <= 1'b0;
                    end else if (jog_since_wr >= 32'(smps_pkg::WRITE_INTERVAL_MS)) begin
                        r_jog_last <= r_now;
                    end
                end
                smps_pkg::S_SM3: r_s <= r_p[32:16];
                smps_pkg::S_JOG_WR: begin
                    r_cmd_angle <= jog_angle[7:0];
                    r_wrote     <= 1'b1;
                end
                smps_pkg::S_THINK: begin
                    r_is_think <= 1'b1;
                    if (think_since_wr >= 32'(smps_pkg::WRITE_INTERVAL_MS)) begin
                        r_think_last <= r_now;
                        if (think_since >= 32'(smps_pkg::EASE_IN_MS)) begin
                            r_s <= 17'd65536;
                        end
                    end
                end
                smps_pkg::S_TH_WR: begin
                    r_cmd_angle <= f_angle(sum_q[11:0], r_safe_min, r_safe_max);
                    r_wrote     <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    a_div_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(div_start && div_busy))
        else $error("divider restarted while busy");

    a_frame_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pat_act |-> (r_frame < 3'd5))
        else $error("waggle active past last frame");

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.angle <= 8'd180))
        else $error("angle out of range");

endmodule
